// File: rtl/stil_pkg.sv
// Shared constants, types and command/status structs for the sorted-table lookup.
`default_nettype none
package stil_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam int SCAN_THRESHOLD = 32;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_QUERY_SQ = 2'd1;
	localparam logic [1:0] CMD_QUERY_RAD = 2'd2;

	// Memory read select codes.
	localparam logic [2:0] RD_LAST = 3'd0;
	localparam logic [2:0] RD_LO = 3'd1;
	localparam logic [2:0] RD_HI = 3'd2;
	localparam logic [2:0] RD_MID = 3'd3;
	localparam logic [2:0] RD_PREV = 3'd4;

	// Datapath operation codes.
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_SQUARE = 4'd2;
	localparam logic [3:0] OP_ISSUE = 4'd3;
	localparam logic [3:0] OP_CHECK_LAST = 4'd4;
	localparam logic [3:0] OP_TAKE_DLO = 4'd5;
	localparam logic [3:0] OP_TAKE_DHI = 4'd6;
	localparam logic [3:0] OP_DIV_START = 4'd7;
	localparam logic [3:0] OP_MID_UPDATE = 4'd8;
	localparam logic [3:0] OP_SCAN_STEP = 4'd9;
	localparam logic [3:0] OP_TAKE_FOUND = 4'd10;
	localparam logic [3:0] OP_TAKE_PREV = 4'd11;
	localparam logic [3:0] OP_WEIGHT = 4'd12;
	localparam logic [3:0] OP_BLEND = 4'd13;
	localparam logic [3:0] OP_FINISH = 4'd14;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] rd_sel;
		logic       rd_en;
		logic       wr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic beyond;
		logic narrow_more;
		logic scan_more;
		logic at_zero;
		logic div_busy;
	} dp_status_t;
endpackage
`default_nettype wire

// File: rtl/stil_divider.sv
// Radix-2 restoring divider for 64 by 32 bit unsigned quotients.
`default_nettype none
module stil_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [63:0]      quotient
);
	logic [6:0]  count_q;
	logic [32:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] div_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[63]};
	assign busy = (count_q != 7'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd0;
		end else if (start) begin
			count_q <= 7'd64;
		end else if (busy) begin
			count_q <= count_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 33'd0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial - {1'b0, div_q};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/stil_datapath.sv
// Table memories, search registers, divider and blend arithmetic.
`default_nettype none
module stil_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire stil_pkg::dp_cmd_t         cmd,
	input  wire logic [1:0]                command,
	input  wire logic [9:0]                entry_index,
	input  wire logic [31:0]               entry_distance_sq,
	input  wire logic [31:0]               entry_reflectance,
	input  wire logic [31:0]               entry_transmittance,
	input  wire logic [31:0]               query_value,
	input  wire logic                      last_in_batch,
	input  wire logic [10:0]               table_length,
	output stil_pkg::dp_status_t           status,
	output logic [31:0]                    result_reflectance,
	output logic [31:0]                    result_transmittance,
	output logic                           beyond_extent,
	output logic                           batch_end
);
	localparam int IW = stil_pkg::IDX_W;
	localparam int F = stil_pkg::FRAC_BITS;
	localparam logic [F:0] ONE = (F + 1)'(1) << F;

	logic [31:0] dist_mem [stil_pkg::TABLE_DEPTH];
	logic [31:0] refl_mem [stil_pkg::TABLE_DEPTH];
	logic [31:0] tran_mem [stil_pkg::TABLE_DEPTH];
	logic [31:0] rd_dist_q, rd_refl_q, rd_tran_q;
	logic [IW-1:0] rd_addr;

	logic [31:0] q_q, dlo_q, dhi_q, pd_q, pr_q, pt_q, fd_q, fr_q, ft_q;
	logic [IW-1:0] lo_q, hi_q, last_idx, mid;
	logic [F:0] w_q;
	logic [63:0] sq_q;
	logic [63:0] acc_r_q, acc_t_q;
	logic [1:0] sq_phase_q;
	logic [1:0] bl_phase_q;
	logic [1:0] cmd_q;
	logic last_batch_q;

	logic div_start, div_busy;
	logic [63:0] div_dividend, div_quot;
	logic [31:0] div_divisor;
	logic [IW:0] span;
	logic [63:0] off;
	logic div_mode_q;      // 0 search step, 1 weight
	logic div_skip_q;
	logic [F:0] w_fixed_q;

	// Effective length minus one.
	always_comb begin
		if (table_length == 11'd0) begin
			last_idx = '0;
		end else if (table_length > 11'(stil_pkg::TABLE_DEPTH)) begin
			last_idx = IW'(stil_pkg::TABLE_DEPTH - 1);
		end else begin
			last_idx = IW'(table_length - 11'd1);
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			stil_pkg::RD_LAST: rd_addr = last_idx;
			stil_pkg::RD_LO:   rd_addr = lo_q;
			stil_pkg::RD_HI:   rd_addr = hi_q;
			stil_pkg::RD_MID:  rd_addr = mid;
			stil_pkg::RD_PREV: rd_addr = lo_q - IW'(1);
			default:           rd_addr = lo_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			dist_mem[entry_index] <= entry_distance_sq;
			refl_mem[entry_index] <= entry_reflectance;
			tran_mem[entry_index] <= entry_transmittance;
		end
		if (cmd.rd_en) begin
			rd_dist_q <= dist_mem[rd_addr];
			rd_refl_q <= refl_mem[rd_addr];
			rd_tran_q <= tran_mem[rd_addr];
		end
	end

	assign span = {1'b0, hi_q} - {1'b0, lo_q};
	always_comb begin
		off = div_quot;
		if (div_skip_q) begin
			off = 64'd0;
		end else if (off > 64'(span - 1'b1)) begin
			off = 64'(span - 1'b1);
		end
	end
	assign mid = lo_q + off[IW-1:0];

	// Divider operands chosen by mode.
	always_comb begin
		div_start = 1'b0;
		div_dividend = 64'd0;
		div_divisor = 32'd1;
		if (cmd.op == stil_pkg::OP_DIV_START && !div_mode_q) begin
			div_start = !((q_q > dlo_q) && (dhi_q > dlo_q)) ? 1'b0 : 1'b1;
			div_dividend = 64'({11'd0, q_q - dlo_q} * {32'd0, span});
			div_divisor = dhi_q - dlo_q;
		end else if (cmd.op == stil_pkg::OP_WEIGHT && div_mode_q) begin
			if (fd_q > pd_q) begin
				div_start = (q_q > pd_q);
				div_dividend = 64'(q_q - pd_q) << F;
				div_divisor = fd_q - pd_q;
			end else if (fd_q < pd_q) begin
				div_start = (q_q < pd_q);
				div_dividend = 64'(pd_q - q_q) << F;
				div_divisor = pd_q - fd_q;
			end
		end
	end

	stil_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .busy(div_busy), .quotient(div_quot)
	);

	logic [F:0] w_div;
	assign w_div = (div_quot > 64'(ONE)) ? ONE : div_quot[F:0];

	// Radius squaring in two 16x32 partial products; blending in phases (weight, two products, result).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_phase_q <= '0;
			bl_phase_q <= '0;
			div_mode_q <= 1'b0;
			beyond_extent <= 1'b0;
			batch_end <= 1'b0;
		end else begin
			case (cmd.op)
				stil_pkg::OP_LOAD: begin
					div_mode_q <= 1'b0;
					sq_phase_q <= 2'd0;
				end
				stil_pkg::OP_SQUARE: sq_phase_q <= sq_phase_q + 2'd1;
				stil_pkg::OP_TAKE_PREV: div_mode_q <= 1'b1;
				stil_pkg::OP_BLEND: bl_phase_q <= bl_phase_q + 2'd1;
				stil_pkg::OP_WEIGHT: bl_phase_q <= 2'd0;
				stil_pkg::OP_FINISH: begin
					beyond_extent <= (q_q > dhi_q);
					batch_end <= last_batch_q;
				end
				default: ;
			endcase
		end
	end

	logic [31:0] qfix;
	assign qfix = (sq_q[63:32 + F] != '0) ? 32'hFFFF_FFFF : sq_q[32 + F - 1:F];

	always_ff @(posedge clk) begin
		case (cmd.op)
			stil_pkg::OP_LOAD: begin
				q_q <= query_value;
				cmd_q <= command;
				last_batch_q <= last_in_batch;
				sq_q <= 64'd0;
				lo_q <= '0;
				hi_q <= last_idx;
			end
			stil_pkg::OP_SQUARE: begin
				if (sq_phase_q == 2'd0) begin
					sq_q <= 64'({32'd0, q_q[15:0]} * {16'd0, q_q});
				end else if (sq_phase_q == 2'd1) begin
					sq_q <= sq_q + (64'({32'd0, q_q[31:16]} * {16'd0, q_q}) << 16);
				end else if (sq_phase_q == 2'd2) begin
					if (cmd_q == stil_pkg::CMD_QUERY_RAD) begin
						q_q <= qfix;
					end
				end
			end
			stil_pkg::OP_CHECK_LAST: dhi_q <= rd_dist_q;
			stil_pkg::OP_TAKE_DLO: dlo_q <= rd_dist_q;
			stil_pkg::OP_TAKE_DHI: dhi_q <= rd_dist_q;
			stil_pkg::OP_DIV_START: div_skip_q <= !((q_q > dlo_q) && (dhi_q > dlo_q));
			stil_pkg::OP_MID_UPDATE: begin
				// rd_dist_q holds d[mid].
				if (q_q > rd_dist_q) begin
					lo_q <= mid + IW'(1);
				end else begin
					hi_q <= mid;
					dhi_q <= rd_dist_q;
				end
			end
			stil_pkg::OP_SCAN_STEP: begin
				lo_q <= lo_q + IW'(1);
			end
			stil_pkg::OP_TAKE_FOUND: begin
				fd_q <= rd_dist_q;
				fr_q <= rd_refl_q;
				ft_q <= rd_tran_q;
				result_reflectance <= rd_refl_q;
				result_transmittance <= rd_tran_q;
			end
			stil_pkg::OP_TAKE_PREV: begin
				pd_q <= rd_dist_q;
				pr_q <= rd_refl_q;
				pt_q <= rd_tran_q;
			end
			stil_pkg::OP_WEIGHT: begin
				if (fd_q > pd_q) begin
					w_fixed_q <= '0;
					div_skip_q <= !(q_q > pd_q);
				end else if (fd_q == pd_q) begin
					w_fixed_q <= (q_q == pd_q) ? (ONE >> 1) : ((q_q > pd_q) ? ONE : '0);
					div_skip_q <= 1'b1;
				end else begin
					w_fixed_q <= '0;
					div_skip_q <= !(q_q < pd_q);
				end
			end
			stil_pkg::OP_BLEND: begin
				if (bl_phase_q == 2'd0) begin
					w_q <= div_skip_q ? w_fixed_q : w_div;
				end else if (bl_phase_q == 2'd1) begin
					acc_r_q <= 64'({32'd0, ONE - w_q} * {17'd0, pr_q});
					acc_t_q <= 64'({32'd0, ONE - w_q} * {17'd0, pt_q});
				end else if (bl_phase_q == 2'd2) begin
					acc_r_q <= acc_r_q + 64'({32'd0, w_q} * {17'd0, fr_q});
					acc_t_q <= acc_t_q + 64'({32'd0, w_q} * {17'd0, ft_q});
				end else begin
					result_reflectance <= acc_r_q[32 + F - 1:F];
					result_transmittance <= acc_t_q[32 + F - 1:F];
				end
			end
			stil_pkg::OP_FINISH: begin
				if (q_q > dhi_q) begin
					result_reflectance <= '0;
					result_transmittance <= '0;
				end
			end
			default: ;
		endcase
		if (cmd.op == stil_pkg::OP_SCAN_STEP || cmd.op == stil_pkg::OP_TAKE_DLO) begin
			if (cmd.op == stil_pkg::OP_SCAN_STEP) begin
				dlo_q <= rd_dist_q;
			end
		end
	end

	assign status.beyond = (q_q > dhi_q);
	assign status.narrow_more = ({1'b0, lo_q} + 11'(stil_pkg::SCAN_THRESHOLD)) < {1'b0, hi_q};
	assign status.scan_more = (lo_q < hi_q) && (q_q > dlo_q);
	assign status.at_zero = (lo_q == '0);
	assign status.div_busy = div_busy;
endmodule
`default_nettype wire

// File: rtl/stil_controller.sv
// Sequencer that steps the datapath through write, search and blend.
`default_nettype none
module stil_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           command,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire stil_pkg::dp_status_t status,
	output stil_pkg::dp_cmd_t         cmd
);
	localparam logic [4:0] S_IDLE = 5'd0, S_SQ0 = 5'd1, S_SQ1 = 5'd2, S_SQ2 = 5'd3,
		S_RLAST = 5'd4, S_CHKLAST = 5'd5, S_TLO = 5'd7,
		S_LOOP = 5'd8, S_DIV = 5'd9, S_DIVW = 5'd10,
		S_UPD = 5'd12, S_RLO2 = 5'd13, S_TLO2 = 5'd14, S_SCAN = 5'd15,
		S_RFOUND = 5'd16, S_TFOUND = 5'd17, S_TPREV = 5'd18, S_WGT = 5'd19,
		S_WDIV = 5'd20, S_BL = 5'd21, S_FIN = 5'd22, S_OUT = 5'd23,
		S_SCANRD = 5'd24;

	logic [4:0] state_q, state_d;
	logic [1:0] bl_q;
	logic out_hold;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (command == stil_pkg::CMD_WRITE) begin
						cmd.wr_en = 1'b1;
					end else if (command == stil_pkg::CMD_QUERY_SQ ||
						command == stil_pkg::CMD_QUERY_RAD) begin
						cmd.op = stil_pkg::OP_LOAD;
						state_d = S_SQ0;
					end
				end
			end
			S_SQ0: begin cmd.op = stil_pkg::OP_SQUARE; state_d = S_SQ1; end
			S_SQ1: begin cmd.op = stil_pkg::OP_SQUARE; state_d = S_SQ2; end
			S_SQ2: begin
				cmd.op = stil_pkg::OP_SQUARE;
				cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_LAST;
				state_d = S_CHKLAST;
			end
			S_CHKLAST: begin
				cmd.op = stil_pkg::OP_CHECK_LAST;
				state_d = S_RLAST;
			end
			S_RLAST: begin
				if (status.beyond) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_LO;
					state_d = S_TLO;
				end
			end
			S_TLO: begin cmd.op = stil_pkg::OP_TAKE_DLO; state_d = S_LOOP; end
			S_LOOP: begin
				state_d = status.narrow_more ? S_DIV : S_SCAN;
			end
			S_DIV: begin cmd.op = stil_pkg::OP_DIV_START; state_d = S_DIVW; end
			S_DIVW: begin
				if (!status.div_busy) begin
					cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_MID;
					state_d = S_UPD;
				end
			end
			S_UPD: begin cmd.op = stil_pkg::OP_MID_UPDATE; state_d = S_RLO2; end
			S_RLO2: begin
				cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_LO;
				state_d = S_TLO;
			end
			S_SCAN: begin
				if (status.scan_more) begin
					cmd.op = stil_pkg::OP_SCAN_STEP;
					state_d = S_SCANRD;
				end else begin
					cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_LO;
					state_d = S_TFOUND;
				end
			end
			S_SCANRD: begin
				cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_LO;
				state_d = S_TLO2;
			end
			S_TLO2: begin cmd.op = stil_pkg::OP_TAKE_DLO; state_d = S_SCAN; end
			S_TFOUND: begin
				cmd.op = stil_pkg::OP_TAKE_FOUND;
				if (status.at_zero) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RFOUND;
				end
			end
			S_RFOUND: begin
				cmd.rd_en = 1'b1; cmd.rd_sel = stil_pkg::RD_PREV;
				state_d = S_TPREV;
			end
			S_TPREV: begin cmd.op = stil_pkg::OP_TAKE_PREV; state_d = S_WGT; end
			S_WGT: begin cmd.op = stil_pkg::OP_WEIGHT; state_d = S_WDIV; end
			S_WDIV: begin
				if (!status.div_busy) begin
					state_d = S_BL;
				end
			end
			S_BL: begin
				cmd.op = stil_pkg::OP_BLEND;
				if (bl_q == 2'd3) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin cmd.op = stil_pkg::OP_FINISH; state_d = S_OUT; end
			S_OUT: begin
				if (out_hold) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_hold = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bl_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == S_BL) begin
				bl_q <= bl_q + 2'd1;
			end else begin
				bl_q <= 2'd0;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/sorted_table_interpolating_lookup.sv
// Top level of the sorted-table interpolating lookup.
// A write word is stored as it is accepted. A query runs setup (load, squaring and the
// last-entry check), interpolation search steps that each wait on the 64-step serial
// divider, a scan with one memory read per scanned entry, then weight division and blend.
// One word is worked on at a time. Reset clears control state and sets table_length to 1;
// the table memories hold no defined contents until written.
`default_nettype none
module sorted_table_interpolating_lookup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [9:0]  entry_index,
	input  wire logic [31:0] entry_distance_sq,
	input  wire logic [31:0] entry_reflectance,
	input  wire logic [31:0] entry_transmittance,
	input  wire logic [31:0] query_value,
	input  wire logic        last_in_batch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_reflectance,
	output logic [31:0]      result_transmittance,
	output logic             beyond_extent,
	output logic             batch_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);
	stil_pkg::dp_cmd_t    cmd;
	stil_pkg::dp_status_t status;
	logic [10:0]          table_length_q;

	// The length register is written whenever a configuration word arrives.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= 11'd1;
		end else if (cfg_valid) begin
			table_length_q <= cfg_data;
		end
	end

	// The controller sequences memory reads, divider starts and blend phases.
	stil_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	// The datapath holds the table and all search and blend arithmetic.
	stil_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .command(command),
		.entry_index(entry_index), .entry_distance_sq(entry_distance_sq),
		.entry_reflectance(entry_reflectance), .entry_transmittance(entry_transmittance),
		.query_value(query_value), .last_in_batch(last_in_batch),
		.table_length(table_length_q), .status(status),
		.result_reflectance(result_reflectance), .result_transmittance(result_transmittance),
		.beyond_extent(beyond_extent), .batch_end(batch_end)
	);
endmodule
`default_nettype wire
